// ===== src/cwc_pkg.sv =====
// Shared types, codes and helpers of the congestion window controller.
// No dependencies; the register file, core, top and bench refer to it by scoped names.
package cwc_pkg;

	// Default size of the sequence number space (range 4 to 64)
	localparam int SEQ_SPACE_DEF = 64;

	// Configuration register map
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_CWND      = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_SSTHRESH = 1'd1;

	localparam logic [7:0] MAX_CWND_RST      = 8'd64;
	localparam logic [7:0] INIT_SSTHRESH_RST = 8'd40;

	// Request types
	localparam logic [1:0] REQ_SEND    = 2'd0;
	localparam logic [1:0] REQ_ACK     = 2'd1;
	localparam logic [1:0] REQ_TIMEOUT = 2'd2;

	// Mode codes as reported on cc_mode
	localparam logic [1:0] CC_SLOW_START = 2'd0;
	localparam logic [1:0] CC_AVOIDANCE  = 2'd1;
	localparam logic [1:0] CC_FAST_RECOV = 2'd2;

	localparam logic [7:0] DUP_ACK_LIMIT = 8'd3;

	typedef enum logic [2:0] {
		MODE_SS = 3'b001,
		MODE_CA = 3'b010,
		MODE_FR = 3'b100
	} mode_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] queued_count;
		logic [5:0] ack_number;
	} item_t;

	typedef struct packed {
		logic [5:0] first_seqno;
		logic [5:0] granted_count;
		logic       is_duplicate;
		logic [5:0] acked_count;
		logic [7:0] window_size;
		logic [7:0] slow_start_threshold;
		logic [1:0] cc_mode;
		logic [5:0] packets_in_flight;
	} result_t;

	function automatic logic [7:0] sat_window(logic [8:0] v, logic [7:0] lim);
		return (v > {1'b0, lim}) ? lim : v[7:0];
	endfunction

	function automatic logic [1:0] mode_code(mode_t m);
		logic [1:0] c;
		case (m)
			MODE_CA: c = CC_AVOIDANCE;
			MODE_FR: c = CC_FAST_RECOV;
			default: c = CC_SLOW_START;
		endcase
		return c;
	endfunction

endpackage

// ===== src/cwc_if.sv =====
// Valid/ready channel interfaces for requests and results.
// Does not depend on cwc_pkg; the field widths are fixed here.
interface cwc_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [7:0] queued_count;
	logic [5:0] ack_number;

	modport source(output valid, req_type, queued_count, ack_number, input ready);
	modport sink(input valid, req_type, queued_count, ack_number, output ready);
endinterface

interface cwc_res_if;
	logic       valid;
	logic       ready;
	logic [5:0] first_seqno;
	logic [5:0] granted_count;
	logic       is_duplicate;
	logic [5:0] acked_count;
	logic [7:0] window_size;
	logic [7:0] slow_start_threshold;
	logic [1:0] cc_mode;
	logic [5:0] packets_in_flight;

	modport source(output valid, first_seqno, granted_count, is_duplicate, acked_count,
		window_size, slow_start_threshold, cc_mode, packets_in_flight, input ready);
	modport sink(input valid, first_seqno, granted_count, is_duplicate, acked_count,
		window_size, slow_start_threshold, cc_mode, packets_in_flight, output ready);
endinterface

// ===== src/cwc_cfg_regs.sv =====
// Configuration register file of the congestion window controller.
// Depends on cwc_pkg for the register map and reset values.
module cwc_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          we,
	input  logic [cwc_pkg::CFG_IDX_W-1:0] index,
	input  logic [7:0]                    wdata,
	output logic [7:0]                    max_cwnd
);

	logic [7:0] max_cwnd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_cwnd_q <= cwc_pkg::MAX_CWND_RST;
		end else if (we) begin
			case (index)
				cwc_pkg::REG_MAX_CWND: begin
					max_cwnd_q <= wdata;
				end
				// threshold is seeded only by reset, from the register's reset value
				cwc_pkg::REG_INIT_SSTHRESH: begin
				end
				default: begin
				end
			endcase
		end
	end

	assign max_cwnd = max_cwnd_q;

endmodule

// ===== src/cwc_core.sv =====
// Congestion state (window, threshold, mode, sequence tracking) and its
// registered update for one request, taken when en is high. Depends on cwc_pkg.
module cwc_core #(
	parameter int SEQ_SPACE = cwc_pkg::SEQ_SPACE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  cwc_pkg::item_t    item,
	input  logic [7:0]        max_cwnd,
	output cwc_pkg::result_t  res
);

	localparam int SW = $clog2(SEQ_SPACE);
	localparam logic [SW:0]   SPACE        = (SW+1)'(SEQ_SPACE);
	localparam logic [SW-1:0] LAST_SEQ     = SW'(SEQ_SPACE - 1);
	localparam logic [5:0]    LAST_ACK_RST = 6'((SEQ_SPACE - 1) % 64);
	localparam logic [8:0]    SPACE9       = 9'(SEQ_SPACE);

	logic [7:0]      cwnd_q, cwnd_n;
	logic [7:0]      ssthresh_q, ssthresh_n;
	cwc_pkg::mode_t  mode_q, mode_n;
	logic [7:0]      dup_q, dup_n;
	logic [5:0]      last_ack_q, last_ack_n;
	logic [SW-1:0]   next_seq_q, next_seq_n;
	logic [SW-1:0]   inflight_q, inflight_n;

	logic [7:0]      lim;
	logic [SW-1:0]   free_slots;
	logic [7:0]      g_min;
	logic [SW-1:0]   granted;
	logic [SW:0]     seq_sum;
	logic [SW-1:0]   seq_adv;
	logic [SW:0]     old_diff, dist_diff;
	logic [SW-1:0]   oldest, ack_dist, ack_sw, rel_cnt;
	logic            ack_in_rng, ack_dup;
	logic [7:0]      dup_inc;

	always_comb begin
		lim = (max_cwnd == 8'd0) ? 8'd1 : max_cwnd;

		// send: grant min(window, queued, free slots)
		free_slots = LAST_SEQ - inflight_q;
		g_min = (item.queued_count < cwnd_q) ? item.queued_count : cwnd_q;
		granted = (8'(free_slots) < g_min) ? free_slots : SW'(g_min);
		seq_sum = {1'b0, next_seq_q} + {1'b0, granted};
		seq_adv = (seq_sum >= SPACE) ? SW'(seq_sum - SPACE) : seq_sum[SW-1:0];

		// ack: in-flight numbers end just before next_seq
		ack_in_rng = {3'b0, item.ack_number} < SPACE9;
		ack_sw = SW'(item.ack_number);
		old_diff = {1'b0, next_seq_q} + SPACE - {1'b0, inflight_q};
		oldest = (old_diff >= SPACE) ? SW'(old_diff - SPACE) : old_diff[SW-1:0];
		dist_diff = {1'b0, ack_sw} + SPACE - {1'b0, oldest};
		ack_dist = (dist_diff >= SPACE) ? SW'(dist_diff - SPACE) : dist_diff[SW-1:0];
		rel_cnt = (ack_in_rng && (ack_dist < inflight_q)) ? ack_dist + SW'(1) : '0;
		ack_dup = (item.ack_number == last_ack_q);
		dup_inc = (dup_q == 8'hFF) ? dup_q : dup_q + 8'd1;
	end

	always_comb begin
		cwnd_n     = cwnd_q;
		ssthresh_n = ssthresh_q;
		mode_n     = mode_q;
		dup_n      = dup_q;
		last_ack_n = last_ack_q;
		next_seq_n = next_seq_q;
		inflight_n = inflight_q;
		res        = '0;

		case (item.req_type)
			cwc_pkg::REQ_SEND: begin
				res.first_seqno   = 6'(next_seq_q);
				res.granted_count = 6'(granted);
				next_seq_n        = seq_adv;
				inflight_n        = inflight_q + granted;
			end
			cwc_pkg::REQ_ACK: begin
				if (ack_dup) begin
					res.is_duplicate = 1'b1;
					dup_n = dup_inc;
					if (mode_q == cwc_pkg::MODE_FR) begin
						cwnd_n = cwc_pkg::sat_window({1'b0, cwnd_q} + 9'd1, lim);
					end else if (dup_inc == cwc_pkg::DUP_ACK_LIMIT) begin
						mode_n     = cwc_pkg::MODE_FR;
						ssthresh_n = cwnd_q >> 1;
						cwnd_n     = cwc_pkg::sat_window({1'b0, cwnd_q} + 9'd3, lim);
					end
				end else begin
					res.acked_count = 6'(rel_cnt);
					inflight_n = inflight_q - rel_cnt;
					last_ack_n = item.ack_number;
					dup_n      = '0;
					if (mode_q == cwc_pkg::MODE_SS) begin
						cwnd_n = cwc_pkg::sat_window({1'b0, cwnd_q} + 9'(rel_cnt), lim);
						if (cwnd_n >= ssthresh_q) begin
							mode_n = cwc_pkg::MODE_CA;
						end
					end else if (mode_q == cwc_pkg::MODE_FR) begin
						mode_n = cwc_pkg::MODE_CA;
						cwnd_n = cwc_pkg::sat_window({1'b0, ssthresh_q}, lim);
					end
				end
			end
			cwc_pkg::REQ_TIMEOUT: begin
				mode_n     = cwc_pkg::MODE_SS;
				ssthresh_n = cwnd_q >> 1;
				cwnd_n     = 8'd1;
				dup_n      = '0;
			end
			default: begin
			end
		endcase

		res.window_size          = cwnd_n;
		res.slow_start_threshold = ssthresh_n;
		res.cc_mode              = cwc_pkg::mode_code(mode_n);
		res.packets_in_flight    = 6'(inflight_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cwnd_q     <= 8'd1;
			ssthresh_q <= cwc_pkg::INIT_SSTHRESH_RST;
			mode_q     <= cwc_pkg::MODE_SS;
			dup_q      <= '0;
			last_ack_q <= LAST_ACK_RST;
			next_seq_q <= '0;
			inflight_q <= '0;
		end else if (en) begin
			cwnd_q     <= cwnd_n;
			ssthresh_q <= ssthresh_n;
			mode_q     <= mode_n;
			dup_q      <= dup_n;
			last_ack_q <= last_ack_n;
			next_seq_q <= next_seq_n;
			inflight_q <= inflight_n;
		end
	end

endmodule

// ===== src/tcp_congestion_window_controller_top.sv =====
// Sender-side Reno-style congestion window controller. Every request (send,
// ack or timeout) yields exactly one result: the request is registered in
// stage 1, and when stage 1 advances the window state is updated and the
// result is caught in an output register at the same clock edge. A new
// request is accepted every cycle while results are taken; a stalled result
// holds one request in the input register before ready drops. Sequence
// numbers wrap at SEQ_SPACE (4 to 64). Write configuration only while no
// request is outstanding.
// Depends on cwc_pkg, cwc_if, cwc_cfg_regs and cwc_core.
module tcp_congestion_window_controller_top #(
	parameter int SEQ_SPACE = cwc_pkg::SEQ_SPACE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	cwc_req_if.sink                       req,
	cwc_res_if.source                     res,
	input  logic                          cfg_we,
	input  logic [cwc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_wdata
);

	logic               valid_s1, valid_s2;
	cwc_pkg::item_t     item_s1;
	cwc_pkg::result_t   result_s2, core_res;
	logic               advance;
	logic [7:0]         max_cwnd;

	cwc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.we       (cfg_we),
		.index    (cfg_index),
		.wdata    (cfg_wdata),
		.max_cwnd (max_cwnd)
	);

	cwc_core #(
		.SEQ_SPACE (SEQ_SPACE)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance),
		.item     (item_s1),
		.max_cwnd (max_cwnd),
		.res      (core_res)
	);

	// stage 1 moves on when the result register is free or being drained
	assign advance   = valid_s1 && (!valid_s2 || res.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req.valid && req.ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (res.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.req_type     <= req.req_type;
			item_s1.queued_count <= req.queued_count;
			item_s1.ack_number   <= req.ack_number;
		end
		if (advance) begin
			result_s2 <= core_res;
		end
	end

	assign res.valid                = valid_s2;
	assign res.first_seqno          = result_s2.first_seqno;
	assign res.granted_count        = result_s2.granted_count;
	assign res.is_duplicate         = result_s2.is_duplicate;
	assign res.acked_count          = result_s2.acked_count;
	assign res.window_size          = result_s2.window_size;
	assign res.slow_start_threshold = result_s2.slow_start_threshold;
	assign res.cc_mode              = result_s2.cc_mode;
	assign res.packets_in_flight    = result_s2.packets_in_flight;

endmodule

// ===== src/cwc_checker.sv =====
// Port-level checks on the result channel of the controller, and the bind
// that attaches them to tcp_congestion_window_controller_top.
module cwc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [5:0] first_seqno,
	input logic [5:0] granted_count,
	input logic       is_duplicate,
	input logic [5:0] acked_count,
	input logic [7:0] window_size,
	input logic [1:0] cc_mode
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(window_size) && $stable(cc_mode)
			&& $stable(acked_count) && $stable(granted_count))
		else $error("stalled result changed");

	// a grant only comes from a send request
	a_grant_only_send: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && granted_count != 6'd0 |-> !is_duplicate && acked_count == 6'd0)
		else $error("grant reported together with ack fields");

	// a duplicate ack releases nothing and grants nothing
	a_dup_no_release: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && is_duplicate |-> acked_count == 6'd0 && granted_count == 6'd0
			&& first_seqno == 6'd0)
		else $error("duplicate ack carries release or grant");

endmodule

bind tcp_congestion_window_controller_top cwc_checker u_cwc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.first_seqno   (res.first_seqno),
	.granted_count (res.granted_count),
	.is_duplicate  (res.is_duplicate),
	.acked_count   (res.acked_count),
	.window_size   (res.window_size),
	.cc_mode       (res.cc_mode)
);

// ===== dv/tcp_congestion_window_controller_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the congestion window controller: directed and random
// send/ack/timeout requests, field-by-field result checks against an in-bench model.
// Depends on cwc_pkg, cwc_if and tcp_congestion_window_controller_top from src.
module tcp_congestion_window_controller_top_tb;

	localparam int SEQ = cwc_pkg::SEQ_SPACE_DEF;
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 300000;
	localparam int RANDOM_ITEMS = 650;
	localparam int PHASES = 6;
	localparam int HOLD_EVERY = 250;
	localparam int HOLD_CYCLES = 100;
	localparam int MAX_PRINTED = 40;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [cwc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [7:0]                    cfg_wdata;

	cwc_req_if req();
	cwc_res_if res();

	tcp_congestion_window_controller_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	class cwnd_scoreboard;
		bit [7:0] max_cwnd;
		bit [7:0] init_ssthresh;
		bit [7:0] cwnd;
		bit [7:0] ssthresh;
		bit [7:0] dup_run;
		bit [1:0] mode;
		bit [5:0] last_ack;
		bit [5:0] next_seq;
		bit [5:0] in_flight;
		cwc_pkg::result_t pending[$];
		int       errors;
		int       checked;
		int       n_send;
		int       n_ack;
		int       n_timeout;
		int       n_unused;
		int       n_recov;
		int       n_dup;
		int       peak_cwnd;
		int       cfg_writes;

		function new();
			max_cwnd = cwc_pkg::MAX_CWND_RST;
			init_ssthresh = cwc_pkg::INIT_SSTHRESH_RST;
			cwnd = 8'd1;
			ssthresh = init_ssthresh;
			mode = cwc_pkg::CC_SLOW_START;
			dup_run = 8'd0;
			last_ack = 6'(SEQ - 1);
			next_seq = 6'd0;
			in_flight = 6'd0;
			errors = 0;
			checked = 0;
			n_send = 0;
			n_ack = 0;
			n_timeout = 0;
			n_unused = 0;
			n_recov = 0;
			n_dup = 0;
			peak_cwnd = 1;
			cfg_writes = 0;
		endfunction

		// threshold register only matters at reset, so a later write is just recorded
		function void write_reg(logic [cwc_pkg::CFG_IDX_W-1:0] idx, logic [7:0] data);
			cfg_writes++;
			if (idx == cwc_pkg::REG_MAX_CWND)
				max_cwnd = data;
			else
				init_ssthresh = data;
		endfunction

		function int clamp_window(int v);
			int lim;
			lim = (max_cwnd == 8'd0) ? 1 : int'(max_cwnd);
			return (v > lim) ? lim : v;
		endfunction

		function int oldest_in_flight();
			return (int'(next_seq) + SEQ - int'(in_flight)) % SEQ;
		endfunction

		// new ack: free everything in flight up to and including the acked number
		function int release_through(bit [5:0] ack);
			int span;
			int count;
			count = 0;
			if (in_flight != 0) begin
				span = (int'(ack) + SEQ - oldest_in_flight()) % SEQ;
				if (span < int'(in_flight))
					count = span + 1;
			end
			in_flight = 6'(int'(in_flight) - count);
			last_ack = ack;
			dup_run = 8'd0;
			return count;
		endfunction

		function void note_request(cwc_pkg::item_t it);
			cwc_pkg::result_t want;
			int      grant;
			int      room;
			int      freed;
			want = '0;
			case (it.req_type)
				cwc_pkg::REQ_SEND: begin
					n_send++;
					room = SEQ - 1 - int'(in_flight);
					grant = cwnd;
					if (int'(it.queued_count) < grant)
						grant = it.queued_count;
					if (room < grant)
						grant = room;
					want.first_seqno = next_seq;
					want.granted_count = 6'(grant);
					next_seq = 6'((int'(next_seq) + grant) % SEQ);
					in_flight = 6'(int'(in_flight) + grant);
				end
				cwc_pkg::REQ_ACK: begin
					n_ack++;
					if (it.ack_number == last_ack) begin
						n_dup++;
						want.is_duplicate = 1'b1;
						if (dup_run != 8'd255)
							dup_run++;
						if (mode == cwc_pkg::CC_FAST_RECOV) begin
							cwnd = 8'(clamp_window(int'(cwnd) + 1));
						end else if (dup_run == cwc_pkg::DUP_ACK_LIMIT) begin
							n_recov++;
							mode = cwc_pkg::CC_FAST_RECOV;
							ssthresh = cwnd / 2;
							cwnd = 8'(clamp_window(int'(cwnd) + 3));
						end
					end else if (mode == cwc_pkg::CC_SLOW_START) begin
						freed = release_through(it.ack_number);
						want.acked_count = 6'(freed);
						cwnd = 8'(clamp_window(int'(cwnd) + freed));
						if (cwnd >= ssthresh)
							mode = cwc_pkg::CC_AVOIDANCE;
					end else begin
						// leaving fast recovery deflates the window before the release
						if (mode == cwc_pkg::CC_FAST_RECOV) begin
							mode = cwc_pkg::CC_AVOIDANCE;
							cwnd = 8'(clamp_window(int'(ssthresh)));
						end
						want.acked_count = 6'(release_through(it.ack_number));
					end
				end
				cwc_pkg::REQ_TIMEOUT: begin
					n_timeout++;
					mode = cwc_pkg::CC_SLOW_START;
					ssthresh = cwnd / 2;
					cwnd = 8'd1;
					dup_run = 8'd0;
				end
				default: n_unused++;
			endcase
			want.window_size = cwnd;
			want.slow_start_threshold = ssthresh;
			want.cc_mode = mode;
			want.packets_in_flight = in_flight;
			if (int'(cwnd) > peak_cwnd)
				peak_cwnd = cwnd;
			pending = {pending, want};
		endfunction

		task report(string msg);
			errors++;
			if (errors <= MAX_PRINTED)
				$display("ERROR at %0t: %s", $realtime, msg);
		endtask

		task cmp_field(string name, int got_v, int want_v);
			if (got_v != want_v)
				report($sformatf("result %0d: %s is %0d, expected %0d",
					checked, name, got_v, want_v));
		endtask

		task check_result(cwc_pkg::result_t got);
			cwc_pkg::result_t want;
			if (pending.size() == 0) begin
				report("result with no request outstanding");
			end else begin
				want = pending.pop_front();
				cmp_field("first_seqno", got.first_seqno, want.first_seqno);
				cmp_field("granted_count", got.granted_count, want.granted_count);
				cmp_field("is_duplicate", got.is_duplicate, want.is_duplicate);
				cmp_field("acked_count", got.acked_count, want.acked_count);
				cmp_field("window_size", got.window_size, want.window_size);
				cmp_field("slow_start_threshold", got.slow_start_threshold,
					want.slow_start_threshold);
				cmp_field("cc_mode", got.cc_mode, want.cc_mode);
				cmp_field("packets_in_flight", got.packets_in_flight,
					want.packets_in_flight);
			end
			checked++;
		endtask
	endclass

	cwnd_scoreboard book;
	int cycles = 0;
	int results_seen = 0;
	int src_calm = 0;
	int snk_calm = 0;
	bit holding = 1'b0;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles, %0d results still due",
				cycles, book.pending.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// per-request or per-result wait, with runs of back-to-back traffic mixed in
	function automatic int draw_gap(inout int calm_left);
		if (holding)
			return 0;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm_left = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 13);
	endfunction

	function automatic cwc_pkg::item_t make_item(logic [1:0] kind, int queued, int ack);
		cwc_pkg::item_t it;
		it.req_type = kind;
		it.queued_count = 8'(queued);
		it.ack_number = 6'(ack);
		return it;
	endfunction

	// mostly acks that land inside the window and duplicate runs, so the
	// recovery path gets exercised; the rest is sends, timeouts, stray acks and junk requests
	function automatic cwc_pkg::item_t pick_item(inout int storm);
		cwc_pkg::item_t it;
		int    roll;
		int    inflight;
		it.req_type = cwc_pkg::REQ_ACK;
		it.queued_count = 8'($urandom_range(0, 255));
		it.ack_number = 6'($urandom_range(0, 63));
		inflight = book.in_flight;
		if (storm > 0) begin
			storm--;
			it.ack_number = book.last_ack;
			return it;
		end
		roll = $urandom_range(0, 99);
		if (roll < 30) begin
			it.req_type = cwc_pkg::REQ_SEND;
			if ($urandom_range(0, 3) == 0)
				it.queued_count = 8'($urandom_range(0, 8));
		end else if (roll < 62) begin
			if (inflight > 0)
				it.ack_number = 6'((book.oldest_in_flight()
					+ int'($urandom_range(0, inflight - 1))) % SEQ);
		end else if (roll < 80) begin
			it.ack_number = book.last_ack;
			if ($urandom_range(0, 2) == 0)
				storm = $urandom_range(2, 7);
		end else if (roll < 86) begin
			it.req_type = cwc_pkg::REQ_TIMEOUT;
		end else if (roll >= 94) begin
			it.req_type = REQ_UNUSED;
		end
		return it;
	endfunction

	task automatic push_request(cwc_pkg::item_t it);
		int gap;
		gap = draw_gap(src_calm);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.req_type <= it.req_type;
		req.queued_count <= it.queued_count;
		req.ack_number <= it.ack_number;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		book.note_request(it);
	endtask

	task automatic drain();
		while (book.pending.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_config(logic [7:0] limit, logic [7:0] thresh);
		cfg_we <= 1'b1;
		cfg_index <= cwc_pkg::REG_MAX_CWND;
		cfg_wdata <= limit;
		@(posedge clk);
		book.write_reg(cwc_pkg::REG_MAX_CWND, limit);
		cfg_index <= cwc_pkg::REG_INIT_SSTHRESH;
		cfg_wdata <= thresh;
		@(posedge clk);
		book.write_reg(cwc_pkg::REG_INIT_SSTHRESH, thresh);
		cfg_we <= 1'b0;
	endtask

	initial begin : result_sink
		cwc_pkg::result_t got;
		int      gap;
		res.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = draw_gap(snk_calm);
			if (gap > 0) begin
				res.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res.ready <= 1'b1;
			@(posedge clk);
			while (!res.valid)
				@(posedge clk);
			got.first_seqno = res.first_seqno;
			got.granted_count = res.granted_count;
			got.is_duplicate = res.is_duplicate;
			got.acked_count = res.acked_count;
			got.window_size = res.window_size;
			got.slow_start_threshold = res.slow_start_threshold;
			got.cc_mode = res.cc_mode;
			got.packets_in_flight = res.packets_in_flight;
			book.check_result(got);
			results_seen++;
			// long back-pressure: the sender keeps pushing until the block stalls
			if (results_seen % HOLD_EVERY == 0) begin
				holding = 1'b1;
				res.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holding = 1'b0;
			end
		end
	end

	initial begin : stimulus
		cwc_pkg::item_t script[$];
		cwc_pkg::item_t it;
		int         counted;
		int         storm;
		logic [7:0] limit;
		logic [7:0] thresh;
		req.valid = 1'b0;
		req.req_type = cwc_pkg::REQ_SEND;
		req.queued_count = 8'd0;
		req.ack_number = 6'd0;
		cfg_we = 1'b0;
		cfg_index = cwc_pkg::REG_MAX_CWND;
		cfg_wdata = 8'd0;
		arst_n = 1'b0;
		book = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed walk under reset settings: first ack repeats the reset value,
		// slow start growth, three duplicates into recovery, exit through an
		// ack outside the window, timeout, unused request type with all bits set
		script = {script, make_item(REQ_UNUSED, 255, 63)};
		script = {script, make_item(cwc_pkg::REQ_ACK, 0, 63)};
		script = {script, make_item(cwc_pkg::REQ_SEND, 0, 0)};
		script = {script, make_item(cwc_pkg::REQ_SEND, 255, 63)};
		script = {script, make_item(cwc_pkg::REQ_ACK, 255, 0)};
		script = {script, make_item(cwc_pkg::REQ_SEND, 255, 0)};
		script = {script, make_item(cwc_pkg::REQ_ACK, 0, 2)};
		script = {script, make_item(cwc_pkg::REQ_SEND, 255, 0)};
		script = {script, make_item(cwc_pkg::REQ_ACK, 0, 3)};
		script = {script, make_item(cwc_pkg::REQ_ACK, 0, 3)};
		script = {script, make_item(cwc_pkg::REQ_ACK, 0, 3)};
		script = {script, make_item(cwc_pkg::REQ_ACK, 0, 3)};
		script = {script, make_item(cwc_pkg::REQ_ACK, 0, 3)};
		script = {script, make_item(cwc_pkg::REQ_SEND, 255, 0)};
		script = {script, make_item(cwc_pkg::REQ_ACK, 0, 63)};
		script = {script, make_item(cwc_pkg::REQ_ACK, 0, 10)};
		script = {script, make_item(cwc_pkg::REQ_ACK, 0, 10)};
		script = {script, make_item(cwc_pkg::REQ_TIMEOUT, 255, 63)};
		script = {script, make_item(cwc_pkg::REQ_ACK, 0, 15)};
		script = {script, make_item(cwc_pkg::REQ_SEND, 3, 0)};
		script = {script, make_item(REQ_UNUSED, 0, 0)};
		script = {script, make_item(cwc_pkg::REQ_TIMEOUT, 0, 0)};
		script = {script, make_item(cwc_pkg::REQ_SEND, 128, 32)};
		foreach (script[i])
			push_request(script[i]);
		req.valid <= 1'b0;

		for (int phase = 0; phase < PHASES; phase++) begin
			drain();
			case (phase)
				0: begin
					limit = 8'd255;
					thresh = 8'd0;
				end
				1: begin
					limit = 8'd1;
					thresh = 8'd255;
				end
				2: begin
					limit = 8'd0;
					thresh = cwc_pkg::INIT_SSTHRESH_RST;
				end
				3: begin
					limit = 8'($urandom_range(2, 254));
					thresh = 8'($urandom_range(0, 255));
				end
				4: begin
					limit = 8'd255;
					thresh = 8'd128;
				end
				default: begin
					limit = cwc_pkg::MAX_CWND_RST;
					thresh = 8'($urandom_range(0, 255));
				end
			endcase
			write_config(limit, thresh);
			counted = 0;
			storm = 0;
			while (counted < RANDOM_ITEMS / PHASES) begin
				it = pick_item(storm);
				counted++;
				push_request(it);
			end
			req.valid <= 1'b0;
		end
		drain();

		$display("Ran %0d sends, %0d acks (%0d repeated), %0d timeouts, %0d unused requests",
			book.n_send, book.n_ack, book.n_dup, book.n_timeout, book.n_unused);
		$display("%0d recovery entries, peak window %0d, %0d register writes, %0d mismatches",
			book.n_recov, book.peak_cwnd, book.cfg_writes, book.errors);
		if (book.errors == 0 && book.pending.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== tcp_congestion_window_controller_top.f =====
src/cwc_pkg.sv
src/cwc_if.sv
src/cwc_cfg_regs.sv
src/cwc_core.sv
src/tcp_congestion_window_controller_top.sv
src/cwc_checker.sv
dv/tcp_congestion_window_controller_top_tb.sv
